// ===== rtl/cfpd_pkg.sv =====
package cfpd_pkg;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_KP_GAIN         = 3'd0,
    REG_KD_GAIN         = 3'd1,
    REG_BASE_SPEED      = 3'd2,
    REG_ROTATION_LIMIT  = 3'd3,
    REG_NOISE_THRESHOLD = 3'd4,
    REG_OBSTRUCTED_MM   = 3'd5,
    REG_CLEAR_MM        = 3'd6,
    REG_CERTAINTY_COUNT = 3'd7
  } cfpd_reg_t;

  typedef enum logic [1:0] {
    EV_FOLLOW   = 2'd0,
    EV_OPENING  = 2'd1,
    EV_DEAD_END = 2'd2
  } cfpd_event_t;

  localparam logic [11:0] KP_GAIN_RST         = 12'd15;
  localparam logic [11:0] KD_GAIN_RST         = 12'd422;
  localparam logic [10:0] BASE_SPEED_RST      = 11'd461;
  localparam logic [10:0] ROTATION_LIMIT_RST  = 11'd280;
  localparam logic [11:0] NOISE_THRESHOLD_RST = 12'd100;
  localparam logic [12:0] OBSTRUCTED_MM_RST   = 13'd70;
  localparam logic [12:0] CLEAR_MM_RST        = 13'd120;
  localparam logic [3:0]  CERTAINTY_COUNT_RST = 4'd3;

  localparam logic signed [12:0] SPEED_MAX = 13'sd2047;
  localparam logic signed [12:0] SPEED_MIN = -13'sd2048;

  typedef struct packed {
    logic [11:0] kp_gain;
    logic [11:0] kd_gain;
    logic [10:0] base_speed;
    logic [10:0] rotation_limit;
    logic [11:0] noise_threshold;
    logic [12:0] obstructed_mm;
    logic [12:0] clear_mm;
    logic [3:0]  certainty_count;
  } cfpd_cfg_t;

  typedef struct packed {
    logic signed [11:0] right_speed;
    logic signed [11:0] left_speed;
    logic signed [11:0] steer;
    logic [1:0]         event_res;
  } cfpd_res_t;

endpackage

// ===== rtl/cfpd_in_if.sv =====
interface cfpd_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] right_prox;
  logic [11:0] left_prox;
  logic [12:0] front_dist_mm;
  logic        restart;

  modport source(output valid, right_prox, left_prox, front_dist_mm, restart, input ready);
  modport sink(input valid, right_prox, left_prox, front_dist_mm, restart, output ready);
endinterface

// ===== rtl/cfpd_out_if.sv =====
interface cfpd_out_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] right_speed;
  logic signed [11:0] left_speed;
  logic signed [11:0] steer;
  logic [1:0]         event_res;

  modport source(output valid, right_speed, left_speed, steer, event_res, input ready);
  modport sink(input valid, right_speed, left_speed, steer, event_res, output ready);
endinterface

// ===== rtl/corridor_follow_pd_steering.sv =====
// Channel   Dir  Transfer            Payload
// in_ch     in   valid && ready      right_prox, left_prox, front_dist_mm, restart
// out_ch    out  valid && ready      right_speed, left_speed, steer, event_res
// cfg (APB) in   psel&penable&pwrite 8 registers at 4*i, 32-bit data, pready tied high
//
// Each sample passes from input transfer to result through the input register,
// then through the PD datapath (two multipliers, clamp, saturate) into
// the result register. A new sample can transfer in every cycle unless the output stalls.
// Reset (rst_n low, synchronous) empties both stages, zeroes previous error and
// obstruction count, and loads register defaults.
// A stalled result holds in the result register; the input register keeps
// accepting as long as its sample can advance in the same cycle.
module corridor_follow_pd_steering (
  input  logic                            clk,
  input  logic                            rst_n,
  cfpd_in_if.sink                         in_ch,
  cfpd_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cfpd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cfpd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [cfpd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  cfpd_pkg::cfpd_cfg_t cfg;
  cfpd_pkg::cfpd_res_t res;

  // Input stage
  logic        s1_valid_r;
  logic [11:0] s1_right_r;
  logic [11:0] s1_left_r;
  logic [12:0] s1_front_r;
  logic        s1_restart_r;

  // Result stage
  logic                out_valid_r;
  cfpd_pkg::cfpd_res_t out_res_r;

  logic in_xfer;
  logic s1_move;

  cfpd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cfpd_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .advance       (s1_move),
    .right_prox    (s1_right_r),
    .left_prox     (s1_left_r),
    .front_dist_mm (s1_front_r),
    .restart       (s1_restart_r),
    .res           (res)
  );

  // Advance the input stage whenever the result register is free or being drained.
  assign s1_move     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_move;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Capture payload only on a transfer; hold otherwise.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_right_r   <= in_ch.right_prox;
      s1_left_r    <= in_ch.left_prox;
      s1_front_r   <= in_ch.front_dist_mm;
      s1_restart_r <= in_ch.restart;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.right_speed = out_res_r.right_speed;
  assign out_ch.left_speed  = out_res_r.left_speed;
  assign out_ch.steer       = out_res_r.steer;
  assign out_ch.event_res   = out_res_r.event_res;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !s1_move)
    else $error("pending result overwritten");

  a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_valid_r)
    else $error("accepted sample lost from input stage");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid_r)
    else $error("advanced sample produced no result");

endmodule

// ===== rtl/cfpd_regs.sv =====
module cfpd_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cfpd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cfpd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [cfpd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output cfpd_pkg::cfpd_cfg_t             cfg
);

  cfpd_pkg::cfpd_cfg_t cfg_r;
  cfpd_pkg::cfpd_reg_t reg_sel;
  logic                wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = cfpd_pkg::cfpd_reg_t'(paddr[4:2]);
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_gain         <= cfpd_pkg::KP_GAIN_RST;
      cfg_r.kd_gain         <= cfpd_pkg::KD_GAIN_RST;
      cfg_r.base_speed      <= cfpd_pkg::BASE_SPEED_RST;
      cfg_r.rotation_limit  <= cfpd_pkg::ROTATION_LIMIT_RST;
      cfg_r.noise_threshold <= cfpd_pkg::NOISE_THRESHOLD_RST;
      cfg_r.obstructed_mm   <= cfpd_pkg::OBSTRUCTED_MM_RST;
      cfg_r.clear_mm        <= cfpd_pkg::CLEAR_MM_RST;
      cfg_r.certainty_count <= cfpd_pkg::CERTAINTY_COUNT_RST;
    end else if (wr_en) begin
      case (reg_sel)
        cfpd_pkg::REG_KP_GAIN:         cfg_r.kp_gain         <= pwdata[11:0];
        cfpd_pkg::REG_KD_GAIN:         cfg_r.kd_gain         <= pwdata[11:0];
        cfpd_pkg::REG_BASE_SPEED:      cfg_r.base_speed      <= pwdata[10:0];
        cfpd_pkg::REG_ROTATION_LIMIT:  cfg_r.rotation_limit  <= pwdata[10:0];
        cfpd_pkg::REG_NOISE_THRESHOLD: cfg_r.noise_threshold <= pwdata[11:0];
        cfpd_pkg::REG_OBSTRUCTED_MM:   cfg_r.obstructed_mm   <= pwdata[12:0];
        cfpd_pkg::REG_CLEAR_MM:        cfg_r.clear_mm        <= pwdata[12:0];
        cfpd_pkg::REG_CERTAINTY_COUNT: cfg_r.certainty_count <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      cfpd_pkg::REG_KP_GAIN:         prdata = 32'(cfg_r.kp_gain);
      cfpd_pkg::REG_KD_GAIN:         prdata = 32'(cfg_r.kd_gain);
      cfpd_pkg::REG_BASE_SPEED:      prdata = 32'(cfg_r.base_speed);
      cfpd_pkg::REG_ROTATION_LIMIT:  prdata = 32'(cfg_r.rotation_limit);
      cfpd_pkg::REG_NOISE_THRESHOLD: prdata = 32'(cfg_r.noise_threshold);
      cfpd_pkg::REG_OBSTRUCTED_MM:   prdata = 32'(cfg_r.obstructed_mm);
      cfpd_pkg::REG_CLEAR_MM:        prdata = 32'(cfg_r.clear_mm);
      cfpd_pkg::REG_CERTAINTY_COUNT: prdata = 32'(cfg_r.certainty_count);
      default:                       prdata = '0;
    endcase
  end

endmodule

// ===== rtl/cfpd_core.sv =====
module cfpd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  cfpd_pkg::cfpd_cfg_t cfg,
  input  logic                advance,
  input  logic [11:0]         right_prox,
  input  logic [11:0]         left_prox,
  input  logic [12:0]         front_dist_mm,
  input  logic                restart,
  output cfpd_pkg::cfpd_res_t res
);

  logic signed [12:0] prev_err_r;
  logic [3:0]         obs_cnt_r;
  logic [3:0]         obs_cnt_nxt;

  logic signed [12:0] err;
  logic signed [12:0] prev;
  logic signed [13:0] diff;
  logic signed [25:0] kp_prod;
  logic signed [26:0] kd_prod;
  logic signed [25:0] kp_bias;
  logic signed [26:0] kd_bias;
  logic signed [17:0] kp_term;
  logic signed [18:0] kd_term;
  logic signed [19:0] corr;
  logic signed [19:0] lim;
  logic signed [19:0] corr_cl;
  logic signed [11:0] steer;
  logic signed [12:0] r_sum;
  logic signed [12:0] l_sum;
  cfpd_pkg::cfpd_event_t ev;

  assign err  = $signed({1'b0, right_prox}) - $signed({1'b0, left_prox});
  assign prev = restart ? 13'sd0 : prev_err_r;
  assign diff = 14'(err) - 14'(prev);

  assign kp_prod = $signed({1'b0, cfg.kp_gain}) * err;
  assign kd_prod = $signed({1'b0, cfg.kd_gain}) * diff;

  // Bias negative products so the arithmetic shift truncates toward zero.
  assign kp_bias = kp_prod + (kp_prod[25] ? 26'sd255 : 26'sd0);
  assign kd_bias = kd_prod + (kd_prod[26] ? 27'sd255 : 27'sd0);
  assign kp_term = kp_bias[25:8];
  assign kd_term = kd_bias[26:8];
  assign corr    = 20'(kp_term) + 20'(kd_term);

  assign lim = $signed({9'd0, cfg.rotation_limit});

  always_comb begin
    if (corr > lim) begin
      corr_cl = lim;
    end else if (corr < -lim) begin
      corr_cl = -lim;
    end else begin
      corr_cl = corr;
    end
  end

  assign steer = corr_cl[11:0];
  assign r_sum = $signed({2'b00, cfg.base_speed}) + 13'(steer);
  assign l_sum = $signed({2'b00, cfg.base_speed}) - 13'(steer);

  always_comb begin
    ev          = cfpd_pkg::EV_FOLLOW;
    obs_cnt_nxt = obs_cnt_r;
    if ((right_prox < cfg.noise_threshold) || (left_prox < cfg.noise_threshold)) begin
      ev = cfpd_pkg::EV_OPENING;
    end else if (front_dist_mm <= cfg.obstructed_mm) begin
      if (obs_cnt_r >= cfg.certainty_count) begin
        ev          = cfpd_pkg::EV_DEAD_END;
        obs_cnt_nxt = '0;
      end else begin
        obs_cnt_nxt = obs_cnt_r + 4'd1;
      end
    end else if (front_dist_mm >= cfg.clear_mm) begin
      obs_cnt_nxt = '0;
    end
  end

  always_comb begin
    if (r_sum > cfpd_pkg::SPEED_MAX) begin
      res.right_speed = cfpd_pkg::SPEED_MAX[11:0];
    end else if (r_sum < cfpd_pkg::SPEED_MIN) begin
      res.right_speed = cfpd_pkg::SPEED_MIN[11:0];
    end else begin
      res.right_speed = r_sum[11:0];
    end
    if (l_sum > cfpd_pkg::SPEED_MAX) begin
      res.left_speed = cfpd_pkg::SPEED_MAX[11:0];
    end else if (l_sum < cfpd_pkg::SPEED_MIN) begin
      res.left_speed = cfpd_pkg::SPEED_MIN[11:0];
    end else begin
      res.left_speed = l_sum[11:0];
    end
    res.steer     = steer;
    res.event_res = ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      obs_cnt_r  <= '0;
    end else if (advance) begin
      prev_err_r <= err;
      obs_cnt_r  <= obs_cnt_nxt;
    end
  end

  a_dead_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (ev == cfpd_pkg::EV_DEAD_END) |=> (obs_cnt_r == 4'd0))
    else $error("obstruction count not cleared after dead end");

  a_err_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (prev_err_r == $past(err)))
    else $error("previous error not updated");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(prev_err_r) && $stable(obs_cnt_r)))
    else $error("state changed without a sample");

  a_steer_limit: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> ((corr_cl <= lim) && (corr_cl >= -lim)))
    else $error("steer outside rotation limit");

endmodule

// ===== sim/corridor_follow_pd_steering_checker.sv =====
`timescale 1ns / 1ps

module corridor_follow_pd_steering_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  cfpd_in_if                              in_ch,
  cfpd_out_if                             out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cfpd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cfpd_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                            pready,
  output int                              mismatches,
  output int                              outstanding
);

  localparam cfpd_pkg::cfpd_cfg_t GAINS_AT_RESET = '{
    cfpd_pkg::KP_GAIN_RST, cfpd_pkg::KD_GAIN_RST, cfpd_pkg::BASE_SPEED_RST,
    cfpd_pkg::ROTATION_LIMIT_RST, cfpd_pkg::NOISE_THRESHOLD_RST,
    cfpd_pkg::OBSTRUCTED_MM_RST, cfpd_pkg::CLEAR_MM_RST, cfpd_pkg::CERTAINTY_COUNT_RST
  };

  cfpd_pkg::cfpd_cfg_t gains;
  int                  last_error;
  logic [3:0]          blocked_run;
  cfpd_pkg::cfpd_res_t wheel_cmds_q[$];
  int                  fail_total = 0;

  function automatic int wheel_sat(input int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  // PD step plus event classification; updates error history and run counter
  function automatic cfpd_pkg::cfpd_res_t steer_and_classify(input logic [11:0] right,
                                                             input logic [11:0] left,
                                                             input logic [12:0] front,
                                                             input logic        restart);
    int                    err;
    int                    prior;
    int                    corr;
    int                    lim;
    cfpd_pkg::cfpd_event_t ev;
    cfpd_pkg::cfpd_res_t   res;
    err   = int'(right) - int'(left);
    prior = restart ? 0 : last_error;
    corr  = (int'(gains.kp_gain) * err) / 256 +
            (int'(gains.kd_gain) * (err - prior)) / 256;
    last_error = err;
    lim = int'(gains.rotation_limit);
    if (corr > lim) corr = lim;
    else if (corr < -lim) corr = -lim;

    ev = cfpd_pkg::EV_FOLLOW;
    if (right < gains.noise_threshold || left < gains.noise_threshold) begin
      ev = cfpd_pkg::EV_OPENING;
    end else if (front <= gains.obstructed_mm) begin
      if (blocked_run >= gains.certainty_count) begin
        blocked_run = '0;
        ev = cfpd_pkg::EV_DEAD_END;
      end else begin
        blocked_run = blocked_run + 4'd1;
      end
    end else if (front >= gains.clear_mm) begin
      blocked_run = '0;
    end

    res.right_speed = 12'(wheel_sat(int'(gains.base_speed) + corr));
    res.left_speed  = 12'(wheel_sat(int'(gains.base_speed) - corr));
    res.steer       = 12'(corr);
    res.event_res   = ev;
    return res;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_total++;
    end
  endfunction

  always @(posedge clk) begin
    cfpd_pkg::cfpd_res_t want;
    if (!rst_n) begin
      gains       = GAINS_AT_RESET;
      last_error  = 0;
      blocked_run = '0;
      wheel_cmds_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfpd_pkg::cfpd_reg_t'(paddr[cfpd_pkg::CFG_ADDR_W-1:2]))
          cfpd_pkg::REG_KP_GAIN:         gains.kp_gain         = pwdata[11:0];
          cfpd_pkg::REG_KD_GAIN:         gains.kd_gain         = pwdata[11:0];
          cfpd_pkg::REG_BASE_SPEED:      gains.base_speed      = pwdata[10:0];
          cfpd_pkg::REG_ROTATION_LIMIT:  gains.rotation_limit  = pwdata[10:0];
          cfpd_pkg::REG_NOISE_THRESHOLD: gains.noise_threshold = pwdata[11:0];
          cfpd_pkg::REG_OBSTRUCTED_MM:   gains.obstructed_mm   = pwdata[12:0];
          cfpd_pkg::REG_CLEAR_MM:        gains.clear_mm        = pwdata[12:0];
          cfpd_pkg::REG_CERTAINTY_COUNT: gains.certainty_count = pwdata[3:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (wheel_cmds_q.size() == 0) begin
          $error("result transfer with nothing expected: steer %0d", out_ch.steer);
          fail_total++;
        end else begin
          want = wheel_cmds_q.pop_front();
          check_field("right_speed", int'(want.right_speed), int'(out_ch.right_speed));
          check_field("left_speed", int'(want.left_speed), int'(out_ch.left_speed));
          check_field("steer", int'(want.steer), int'(out_ch.steer));
          check_field("event_res", int'(want.event_res), int'(out_ch.event_res));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        wheel_cmds_q.push_back(steer_and_classify(in_ch.right_prox, in_ch.left_prox,
                                                  in_ch.front_dist_mm, in_ch.restart));
      end
    end
    mismatches  <= fail_total;
    outstanding <= wheel_cmds_q.size();
  end

endmodule

// ===== sim/corridor_follow_pd_steering_tb.sv =====
`timescale 1ns / 1ps

module corridor_follow_pd_steering_tb;

  // Items per randomized configuration phase; twelve phases plus the
  // directed opening come to more than 1840 samples in all.
  localparam int RANDOM_PHASES     = 12;
  localparam int ITEMS_PER_PHASE   = 152;
  // Long sink hold-off, well past the two-stage pipeline depth so that the
  // input side backs up while the sender keeps offering.
  localparam int HOLD_OFF_CYCLES   = 48;
  // Quiet cycles after the last expected result: two pipeline stages plus slack.
  localparam int SETTLE_CYCLES     = 4;

  localparam cfpd_pkg::cfpd_cfg_t CFG_AT_RESET = '{
    cfpd_pkg::KP_GAIN_RST, cfpd_pkg::KD_GAIN_RST, cfpd_pkg::BASE_SPEED_RST,
    cfpd_pkg::ROTATION_LIMIT_RST, cfpd_pkg::NOISE_THRESHOLD_RST,
    cfpd_pkg::OBSTRUCTED_MM_RST, cfpd_pkg::CLEAR_MM_RST, cfpd_pkg::CERTAINTY_COUNT_RST
  };

  logic                            clk;
  logic                            rst_n;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [cfpd_pkg::CFG_ADDR_W-1:0] paddr;
  logic [cfpd_pkg::CFG_DATA_W-1:0] pwdata;
  logic [cfpd_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  int                  mismatches;
  int                  outstanding;
  // Bumped by the stimulus to ask the sink for one long hold-off.
  int                  hold_reqs = 0;
  // Shadow of what was last programmed; used only to aim the stimulus.
  cfpd_pkg::cfpd_cfg_t cur_cfg;

  cfpd_in_if  in_ch();
  cfpd_out_if out_ch();

  corridor_follow_pd_steering u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  corridor_follow_pd_steering_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop: far beyond the slowest legal run (all gaps, all stalls).
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // APB write: setup cycle, then access cycle; register loads at the edge
  // where psel, penable, pwrite and pready are all high. Start with an edge
  // so back-to-back writes never drop and raise psel in one step.
  task automatic write_reg(input cfpd_pkg::cfpd_reg_t idx,
                           input logic [cfpd_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_config(input cfpd_pkg::cfpd_cfg_t c);
    write_reg(cfpd_pkg::REG_KP_GAIN,         32'(c.kp_gain));
    write_reg(cfpd_pkg::REG_KD_GAIN,         32'(c.kd_gain));
    write_reg(cfpd_pkg::REG_BASE_SPEED,      32'(c.base_speed));
    write_reg(cfpd_pkg::REG_ROTATION_LIMIT,  32'(c.rotation_limit));
    write_reg(cfpd_pkg::REG_NOISE_THRESHOLD, 32'(c.noise_threshold));
    write_reg(cfpd_pkg::REG_OBSTRUCTED_MM,   32'(c.obstructed_mm));
    write_reg(cfpd_pkg::REG_CLEAR_MM,        32'(c.clear_mm));
    write_reg(cfpd_pkg::REG_CERTAINTY_COUNT, 32'(c.certainty_count));
    cur_cfg = c;
  endtask

  // Offer one sample and hold it until the transfer. Valid stays high into
  // the next sample unless a gap follows, so it is never dropped and raised
  // in the same step.
  task automatic send_sample(input logic [11:0] right, input logic [11:0] left,
                             input logic [12:0] front, input logic restart,
                             input int gap);
    in_ch.valid         <= 1'b1;
    in_ch.right_prox    <= right;
    in_ch.left_prox     <= left;
    in_ch.front_dist_mm <= front;
    in_ch.restart       <= restart;
    do @(posedge clk); while (!in_ch.ready);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, wait for every expected result, then let the pipe settle.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly a real wall (at or above the noise threshold), sometimes an
  // opening, sometimes a raw extreme or full-range value.
  function automatic logic [11:0] side_reading();
    int noise;
    noise = int'(cur_cfg.noise_threshold);
    case ($urandom_range(19, 0))
      0:       return 12'd0;
      1:       return 12'd4095;
      2, 3:    return (noise == 0) ? 12'($urandom_range(4095, 0))
                                   : 12'($urandom_range(noise - 1, 0));
      4:       return 12'($urandom_range(4095, 0));
      default: return 12'($urandom_range(4095, noise));
    endcase
  endfunction

  // Front distance aimed at one band of the obstruction hysteresis.
  function automatic logic [12:0] front_reading(input int band);
    int obs;
    int clr;
    obs = int'(cur_cfg.obstructed_mm);
    clr = int'(cur_cfg.clear_mm);
    case (band)
      0:       return 13'($urandom_range(obs, 0));
      1:       return (clr > obs + 1) ? 13'($urandom_range(clr - 1, obs + 1))
                                      : 13'($urandom_range(8191, 0));
      2:       return 13'($urandom_range(8191, clr));
      default: return 13'($urandom_range(8191, 0));
    endcase
  endfunction

  // Bias register values toward zero, full field, reset value, then the
  // usable range.
  function automatic int pick_setting(input int field_max, input int op_high,
                                      input int rst_val);
    case ($urandom_range(9, 0))
      0, 1:    return 0;
      2:       return field_max;
      3, 4:    return rst_val;
      default: return $urandom_range(op_high, 0);
    endcase
  endfunction

  // Sink side: stall pattern re-picked at random (always ready, coin flip,
  // mostly ready, periodic), plus a long hold-off whenever requested.
  initial begin : sink_side
    int hold_seen;
    int rx_mode;
    int cyc;
    hold_seen = 0;
    rx_mode   = 0;
    cyc       = 0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        if (cyc % 64 == 0) rx_mode = $urandom_range(3, 0);
        case (rx_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(1, 0));
          2:       out_ch.ready <= ($urandom_range(6, 0) != 0);
          default: out_ch.ready <= ((cyc % 5) != 0);
        endcase
        cyc++;
        @(posedge clk);
      end
    end
  end

  initial begin : source_side
    cfpd_pkg::cfpd_cfg_t c;
    int                  sent;
    int                  burst_len;
    int                  band;
    int                  gap;

    // Known values on every input from time zero.
    rst_n               <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.right_prox    <= '0;
    in_ch.left_prox     <= '0;
    in_ch.front_dist_mm <= '0;
    in_ch.restart       <= 1'b0;
    cur_cfg = CFG_AT_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset configuration: field extremes and clamp in both
    // directions (both also openings since one side reads low).
    send_sample(12'd0,    12'd0,    13'd0,    1'b1, 0);
    send_sample(12'd4095, 12'd0,    13'd8191, 1'b0, 1);
    send_sample(12'd0,    12'd4095, 13'd8191, 1'b0, 0);
    send_sample(12'd4095, 12'd4095, 13'd8191, 1'b1, 2);
    send_sample(12'd2000, 12'd1500, 13'd500,  1'b1, 0);
    send_sample(12'd1500, 12'd2000, 13'd500,  1'b0, 0);
    // Hold the sink off while an obstruction run streams in: the pipe fills
    // and the input stalls. Four obstructed samples reach the dead end, the
    // fifth starts a new run.
    hold_reqs <= hold_reqs + 1;
    repeat (5) send_sample(12'd800, 12'd820, 13'd70, 1'b0, 0);
    // Between the thresholds: counter holds; then obstructed again; then clear.
    send_sample(12'd800, 12'd800, 13'd100, 1'b0, 0);
    send_sample(12'd800, 12'd800, 13'd0,   1'b0, 0);
    send_sample(12'd800, 12'd800, 13'd120, 1'b0, 1);
    // Opening wins over an obstructed front and leaves the counter alone.
    send_sample(12'd99,  12'd500, 13'd0,   1'b0, 0);
    send_sample(12'd500, 12'd99,  13'd0,   1'b0, 0);
    // Exactly at the noise threshold is still a wall.
    send_sample(12'd100, 12'd100, 13'd65,  1'b0, 0);

    // Zero certainty, overlapping thresholds, full gains, top speed and limit,
    // no noise floor: every obstructed sample is a dead end, speeds saturate.
    wait_drained();
    c = cur_cfg;
    c.kp_gain         = 12'd4095;
    c.kd_gain         = 12'd4095;
    c.base_speed      = 11'd2047;
    c.rotation_limit  = 11'd2047;
    c.noise_threshold = 12'd0;
    c.obstructed_mm   = 13'd200;
    c.clear_mm        = 13'd150;
    c.certainty_count = 4'd0;
    load_config(c);
    send_sample(12'd4095, 12'd0,    13'd200,  1'b1, 0);
    send_sample(12'd0,    12'd4095, 13'd150,  1'b0, 0);
    send_sample(12'd0,    12'd0,    13'd8191, 1'b0, 0);

    // Zero base, proportional only, widest noise floor, maximum certainty:
    // both wheels swing to both sides of zero.
    wait_drained();
    c.kd_gain         = 12'd0;
    c.base_speed      = 11'd0;
    c.noise_threshold = 12'd4095;
    c.obstructed_mm   = 13'd0;
    c.clear_mm        = 13'd8191;
    c.certainty_count = 4'd15;
    load_config(c);
    send_sample(12'd4095, 12'd0,    13'd0, 1'b1, 0);
    send_sample(12'd0,    12'd4095, 13'd0, 1'b0, 0);
    send_sample(12'd4094, 12'd4095, 13'd1, 1'b0, 0);

    // Random phases: first on reset settings, then on random register sets.
    // Each burst stays in one front band so obstruction runs build up.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      if (ph == 0) begin
        load_config(CFG_AT_RESET);
      end else begin
        c.kp_gain         = 12'(pick_setting(4095, 4095, cfpd_pkg::KP_GAIN_RST));
        c.kd_gain         = 12'(pick_setting(4095, 4095, cfpd_pkg::KD_GAIN_RST));
        c.base_speed      = 11'(pick_setting(2047, 1100, cfpd_pkg::BASE_SPEED_RST));
        c.rotation_limit  = 11'(pick_setting(2047, 1100, cfpd_pkg::ROTATION_LIMIT_RST));
        c.noise_threshold = 12'(pick_setting(4095, 4095, cfpd_pkg::NOISE_THRESHOLD_RST));
        c.obstructed_mm   = 13'(pick_setting(8191, 8191, cfpd_pkg::OBSTRUCTED_MM_RST));
        c.clear_mm        = 13'(pick_setting(8191, 8191, cfpd_pkg::CLEAR_MM_RST));
        c.certainty_count = 4'(pick_setting(15, 15, cfpd_pkg::CERTAINTY_COUNT_RST));
        load_config(c);
      end
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst_len = $urandom_range(20, 1);
        band      = $urandom_range(3, 0);
        if ($urandom_range(29, 0) == 0) hold_reqs <= hold_reqs + 1;
        for (int k = 0; k < burst_len; k++) begin
          gap = (k == burst_len - 1 && $urandom_range(9, 0) >= 3) ?
                $urandom_range(8, 1) : 0;
          send_sample(side_reading(), side_reading(), front_reading(band),
                      (k == 0 && $urandom_range(3, 0) == 0), gap);
        end
        sent += burst_len;
      end
    end

    wait_drained();
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cfpd_pkg.sv
rtl/cfpd_in_if.sv
rtl/cfpd_out_if.sv
rtl/cfpd_regs.sv
rtl/cfpd_core.sv
rtl/corridor_follow_pd_steering.sv
sim/corridor_follow_pd_steering_checker.sv
sim/corridor_follow_pd_steering_tb.sv
